// File: sv/v3au_pkg.sv
// Shared operation codes for the vector arithmetic unit.
`default_nettype none
package v3au_pkg;
  typedef logic [3:0] op_t;

  localparam op_t OP_ADD     = 4'd0;
  localparam op_t OP_SUB     = 4'd1;
  localparam op_t OP_MUL     = 4'd2;
  localparam op_t OP_SCALE   = 4'd3;
  localparam op_t OP_DIV     = 4'd4;
  localparam op_t OP_DOT     = 4'd5;
  localparam op_t OP_CROSS   = 4'd6;
  localparam op_t OP_LEN     = 4'd7;
  localparam op_t OP_LENSQ   = 4'd8;
  localparam op_t OP_NORM    = 4'd9;
  localparam op_t OP_LEN2D   = 4'd10;
  localparam op_t OP_LENSQ2D = 4'd11;
endpackage
`default_nettype wire

// File: sv/v3au_lane.sv
// Product lane: computes x1*y1 - x2*y2 from split partial products over two stages.
`default_nettype none
module v3au_lane #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   x1,
  input  logic signed [W-1:0]   y1,
  input  logic signed [W-1:0]   x2,
  input  logic signed [W-1:0]   y2,
  output logic signed [2*W:0]   p
);
  localparam int HL = W / 2;
  localparam int HH = W - HL;
  localparam int PW = 2 * W + 1;

  logic signed [W-1:0]       xa [2];
  logic signed [W-1:0]       ya [2];
  logic signed [2*HH-1:0]    hh_q [2];
  logic signed [HH+HL:0]     hl_q [2];
  logic signed [HH+HL:0]     lh_q [2];
  logic        [2*HL-1:0]    ll_q [2];
  logic signed [PW-1:0]      m [2];

  assign xa[0] = x1;
  assign ya[0] = y1;
  assign xa[1] = x2;
  assign ya[1] = y2;

  // Form partial products of the high and low halves and hold them
  always_ff @(posedge clk) begin
    for (int j = 0; j < 2; j++) begin
      hh_q[j] <= $signed(xa[j][W-1:HL]) * $signed(ya[j][W-1:HL]);
      hl_q[j] <= $signed(xa[j][W-1:HL]) * $signed({1'b0, ya[j][HL-1:0]});
      lh_q[j] <= $signed({1'b0, xa[j][HL-1:0]}) * $signed(ya[j][W-1:HL]);
      ll_q[j] <= xa[j][HL-1:0] * ya[j][HL-1:0];
    end
  end

  // Align and add the partial products of each multiplier
  always_comb begin
    logic signed [PW-1:0] t_hh;
    logic signed [PW-1:0] t_hl;
    logic signed [PW-1:0] t_lh;
    logic signed [PW-1:0] t_ll;
    for (int j = 0; j < 2; j++) begin
      t_hh = PW'(hh_q[j]);
      t_hl = PW'(hl_q[j]);
      t_lh = PW'(lh_q[j]);
      t_ll = PW'($signed({1'b0, ll_q[j]}));
      m[j] = (t_hh <<< (2 * HL)) + (t_hl <<< HL) + (t_lh <<< HL) + t_ll;
    end
  end

  // Take the difference of the two products
  always_ff @(posedge clk) begin
    p <= m[0] - m[1];
  end
endmodule
`default_nettype wire

// File: sv/v3au_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module v3au_sqrt #(
  parameter int W = 32
) (
  input  logic             clk,
  input  logic [2*W-1:0]   n,
  output logic [W-1:0]     root
);
  localparam int RW = 2 * W + 1;

  logic [RW-1:0] rem_q  [W];
  logic [W-1:0]  root_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam int B = W - 1 - k;
    logic [RW-1:0] rem_in;
    logic [W-1:0]  r_in;
    logic [RW-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = RW'(n);
      assign r_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign r_in   = root_q[k-1];
    end

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    assign trial = (RW'(r_in) << (B + 1)) | (RW'(1) << (2 * B));

    // Keep the trial bit when its square still fits under the remainder
    always_ff @(posedge clk) begin
      if (trial <= rem_in) begin
        rem_q[k]  <= rem_in - trial;
        root_q[k] <= r_in | (W'(1) << B);
      end else begin
        rem_q[k]  <= rem_in;
        root_q[k] <= r_in;
      end
    end
  end

  assign root = root_q[W-1];
endmodule
`default_nettype wire

// File: sv/v3au_div.sv
// Pipelined restoring divider of (num << F) by den, one quotient bit per stage.
`default_nettype none
module v3au_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic           clk,
  input  logic [W-1:0]   num,
  input  logic [W-1:0]   den,
  input  logic           neg,
  output logic [W-1:0]   quo,
  output logic           ovf,
  output logic           neg_out
);
  localparam int NW = W + F;

  logic [NW-1:0] nfull;
  logic [W-1:0]  rem_q [W+1];
  logic [W-1:0]  low_q [W+1];
  logic [W-1:0]  den_q [W+1];
  logic [W-1:0]  q_q   [W+1];
  logic          neg_q [W+1];
  logic          ovf_q [W+1];

  assign nfull = {num, {F{1'b0}}};

  // Flag quotients of 2^W or more, seed the remainder with the high part
  always_ff @(posedge clk) begin
    ovf_q[0] <= NW'(nfull[NW-1:W]) >= NW'(den);
    rem_q[0] <= W'(nfull[NW-1:W]);
    low_q[0] <= nfull[W-1:0];
    den_q[0] <= den;
    q_q[0]   <= '0;
    neg_q[0] <= neg;
  end

  for (genvar k = 1; k <= W; k++) begin : g_stage
    logic [W:0] rem2;
    logic       ge;

    assign rem2 = {rem_q[k-1], low_q[k-1][W-k]};
    assign ge   = rem2 >= {1'b0, den_q[k-1]};

    // Subtract the divisor where it fits and record the quotient bit
    always_ff @(posedge clk) begin
      rem_q[k] <= ge ? W'(rem2 - {1'b0, den_q[k-1]}) : W'(rem2);
      q_q[k]   <= q_q[k-1] | (W'(ge) << (W - k));
      low_q[k] <= low_q[k-1];
      den_q[k] <= den_q[k-1];
      neg_q[k] <= neg_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
    end
  end

  assign quo     = q_q[W];
  assign ovf     = ovf_q[W];
  assign neg_out = neg_q[W];
endmodule
`default_nettype wire

// File: sv/vector3_arithmetic_unit.sv
// Three-component fixed-point vector unit: add, products, cross, length, divide, normalize.
//
//  channel   handshake            payload
//  -------   ------------------   ------------------------------------------------
//  command   start / busy         operation, ax, ay, az, bx, by, bz, scalar_in
//  result    done (one cycle)     rx, ry, rz, scalar_out, saturated, divide_by_zero
//
// An item is taken every cycle; busy stays low since nothing in the pipe ever waits.
// Every item takes the same path whatever its operation, its length set by the square root
// (COMP_WIDTH stages) followed by the divider (COMP_WIDTH+1 stages).
// Results come out in order, one per item; reset clears all valid bits at once.
`default_nettype none
module vector3_arithmetic_unit #(
  parameter int FRAC_BITS  = 16,
  parameter int COMP_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  v3au_pkg::op_t                 operation,
  input  logic signed [COMP_WIDTH-1:0]  ax,
  input  logic signed [COMP_WIDTH-1:0]  ay,
  input  logic signed [COMP_WIDTH-1:0]  az,
  input  logic signed [COMP_WIDTH-1:0]  bx,
  input  logic signed [COMP_WIDTH-1:0]  by,
  input  logic signed [COMP_WIDTH-1:0]  bz,
  input  logic signed [COMP_WIDTH-1:0]  scalar_in,
  output logic                          done,
  output logic signed [COMP_WIDTH-1:0]  rx,
  output logic signed [COMP_WIDTH-1:0]  ry,
  output logic signed [COMP_WIDTH-1:0]  rz,
  output logic signed [COMP_WIDTH-1:0]  scalar_out,
  output logic                          saturated,
  output logic                          divide_by_zero
);
  import v3au_pkg::*;

  localparam int W  = COMP_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int XW = 2 * W + 4;
  localparam int EL = 2 * W + 1;

  localparam logic signed [XW-1:0] MAXV = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] MINV = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] HALF = {{(XW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

  typedef struct packed {
    op_t                 op;
    logic [2:0][W-1:0]   vec;
    logic [W-1:0]        sc;
    logic                sat;
    logic                acc_zero;
    logic                s_zero;
  } early_t;

  typedef struct packed {
    logic [2:0][W-1:0]   a;
    logic [W-1:0]        s;
  } aside_t;

  // Clamp to the component range, flag in the top bit
  function automatic logic [W:0] sat_fn(input logic signed [XW-1:0] v);
    logic [W:0] r;
    if (v > MAXV) begin
      r = {1'b1, MAXV[W-1:0]};
    end else if (v < MINV) begin
      r = {1'b1, MINV[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  // Drop the extra fraction bits, halves toward plus infinity
  function automatic logic signed [XW-1:0] rnd_fn(input logic signed [XW-1:0] v);
    return (v + HALF) >>> F;
  endfunction

  // Apply sign to a quotient magnitude and clamp it
  function automatic logic [W:0] dsat_fn(input logic [W-1:0] q, input logic o,
                                         input logic ng);
    logic [W:0] r;
    if (o) begin
      r = {1'b1, ng ? MINV[W-1:0] : MAXV[W-1:0]};
    end else if (!ng) begin
      r = q[W-1] ? {1'b1, MAXV[W-1:0]} : {1'b0, q};
    end else if (q[W-1] && (q[W-2:0] != '0)) begin
      r = {1'b1, MINV[W-1:0]};
    end else begin
      r = {1'b0, ~q + W'(1)};
    end
    return r;
  endfunction

  logic                  v0, v1, v2, v3;
  op_t                   op0, op1, op2, op3;
  logic signed [W-1:0]   a0 [3];
  logic signed [W-1:0]   b0 [3];
  logic signed [W-1:0]   s0, s1, s2, s3;
  logic [2:0][W-1:0]     a1, a2, a3;
  logic [W:0]            as_now [3];
  logic [W:0]            as1 [3];
  logic [W:0]            as2 [3];
  logic [W:0]            as3 [3];
  logic [W:0]            pr3 [3];
  logic signed [XW-1:0]  sum3;
  logic signed [W-1:0]   x1 [3];
  logic signed [W-1:0]   y1 [3];
  logic signed [W-1:0]   x2 [3];
  logic signed [W-1:0]   y2 [3];
  logic signed [2*W:0]   p [3];
  early_t                e_now;
  early_t                eline [EL];
  logic [EL-1:0]         ev;
  aside_t                aline [W];
  logic [W-1:0]          root;
  logic [W-1:0]          rline [W+1];
  logic                  is_div;
  logic [W-1:0]          den;
  logic [W-1:0]          dnum [3];
  logic                  dnin [3];
  logic [W-1:0]          dq [3];
  logic                  dovf [3];
  logic                  dneg [3];
  logic [W:0]            dres [3];
  logic [W:0]            rsat;
  logic [2:0][W-1:0]     fvec;
  logic [W-1:0]          fsc;
  logic                  fsat;
  logic                  fdz;
  early_t                ef;

  assign busy = 1'b0;

  // Capture the item
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    op0   <= operation;
    a0[0] <= ax;
    a0[1] <= ay;
    a0[2] <= az;
    b0[0] <= bx;
    b0[1] <= by;
    b0[2] <= bz;
    s0    <= scalar_in;
  end

  // Steer operands into the lanes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x1[i] = '0;
      y1[i] = '0;
      x2[i] = '0;
      y2[i] = '0;
    end
    unique case (op0)
      OP_MUL, OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          x1[i] = a0[i];
          y1[i] = b0[i];
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          x1[i] = a0[i];
          y1[i] = s0;
        end
      end
      OP_CROSS: begin
        x1[0] = a0[1]; y1[0] = b0[2]; x2[0] = a0[2]; y2[0] = b0[1];
        x1[1] = a0[2]; y1[1] = b0[0]; x2[1] = a0[0]; y2[1] = b0[2];
        x1[2] = a0[0]; y1[2] = b0[1]; x2[2] = a0[1]; y2[2] = b0[0];
      end
      OP_LEN, OP_LENSQ, OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          x1[i] = a0[i];
          y1[i] = a0[i];
        end
      end
      OP_LEN2D, OP_LENSQ2D: begin
        for (int i = 0; i < 2; i++) begin
          x1[i] = a0[i];
          y1[i] = a0[i];
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    v3au_lane #(.W(W)) u_lane (
      .clk (clk),
      .x1  (x1[g]),
      .y1  (y1[g]),
      .x2  (x2[g]),
      .y2  (y2[g]),
      .p   (p[g])
    );
  end

  // Sum or difference per component, clamped
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      as_now[i] = sat_fn((op0 == OP_SUB) ? XW'(a0[i]) - XW'(b0[i])
                                         : XW'(a0[i]) + XW'(b0[i]));
    end
  end

  // Advance control and side values alongside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
    op1 <= op0;
    op2 <= op1;
    op3 <= op2;
    s1  <= s0;
    s2  <= s1;
    s3  <= s2;
    for (int i = 0; i < 3; i++) begin
      a1[i]  <= a0[i];
      a2[i]  <= a1[i];
      a3[i]  <= a2[i];
      as1[i] <= as_now[i];
      as2[i] <= as1[i];
      as3[i] <= as2[i];
    end
  end

  // Merge: round each lane, and add the lanes for dot and lengths
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pr3[i] <= sat_fn(rnd_fn(XW'(p[i])));
    end
    sum3 <= XW'(p[0]) + XW'(p[1]) + XW'(p[2]);
  end

  // Settle the results that need no root or quotient
  always_comb begin
    logic [W:0] scf;
    scf = sat_fn(rnd_fn(sum3));
    e_now          = '0;
    e_now.op       = op3;
    e_now.acc_zero = (sum3 == '0);
    e_now.s_zero   = (s3 == '0);
    unique case (op3)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          e_now.vec[i] = as3[i][W-1:0];
        end
        e_now.sat = as3[0][W] | as3[1][W] | as3[2][W];
      end
      OP_MUL, OP_SCALE, OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          e_now.vec[i] = pr3[i][W-1:0];
        end
        e_now.sat = pr3[0][W] | pr3[1][W] | pr3[2][W];
      end
      OP_DOT, OP_LENSQ, OP_LENSQ2D: begin
        e_now.sc  = scf[W-1:0];
        e_now.sat = scf[W];
      end
      default: begin
      end
    endcase
  end

  v3au_sqrt #(.W(W)) u_sqrt (
    .clk  (clk),
    .n    (sum3[2*W-1:0]),
    .root (root)
  );

  // Hold early results, vector A and the scalar until root and quotient arrive
  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= '0;
    end else begin
      ev <= {ev[EL-2:0], v3};
    end
    eline[0] <= e_now;
    for (int k = 1; k < EL; k++) begin
      eline[k] <= eline[k-1];
    end
    aline[0].a <= a3;
    aline[0].s <= s3;
    for (int k = 1; k < W; k++) begin
      aline[k] <= aline[k-1];
    end
    rline[0] <= root;
    for (int k = 1; k <= W; k++) begin
      rline[k] <= rline[k-1];
    end
  end

  // Pick the divisor: the scalar for divide, the length for normalize
  always_comb begin
    logic [W-1:0] an;
    is_div = (eline[W-1].op == OP_DIV);
    den    = is_div ? (aline[W-1].s[W-1] ? ~aline[W-1].s + W'(1) : aline[W-1].s) : root;
    for (int i = 0; i < 3; i++) begin
      an      = aline[W-1].a[i];
      dnum[i] = an[W-1] ? ~an + W'(1) : an;
      dnin[i] = an[W-1] ^ (is_div & aline[W-1].s[W-1]);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    v3au_div #(.W(W), .F(F)) u_div (
      .clk     (clk),
      .num     (dnum[g]),
      .den     (den),
      .neg     (dnin[g]),
      .quo     (dq[g]),
      .ovf     (dovf[g]),
      .neg_out (dneg[g])
    );
  end

  // Final selection per operation
  always_comb begin
    ef   = eline[EL-1];
    rsat = rline[W][W-1] ? {1'b1, MAXV[W-1:0]} : {1'b0, rline[W]};
    for (int i = 0; i < 3; i++) begin
      dres[i] = dsat_fn(dq[i], dovf[i], dneg[i]);
    end
    fvec = ef.vec;
    fsc  = ef.sc;
    fsat = ef.sat;
    fdz  = 1'b0;
    unique case (ef.op)
      OP_DIV, OP_NORM: begin
        if ((ef.op == OP_DIV && ef.s_zero) || (ef.op == OP_NORM && ef.acc_zero)) begin
          fvec = '0;
          fsat = 1'b0;
          fdz  = (ef.op == OP_DIV);
        end else begin
          for (int i = 0; i < 3; i++) begin
            fvec[i] = dres[i][W-1:0];
          end
          fsat = dres[0][W] | dres[1][W] | dres[2][W];
        end
      end
      OP_LEN, OP_LEN2D: begin
        fsc  = rsat[W-1:0];
        fsat = rsat[W];
      end
      default: begin
      end
    endcase
  end

  // Present the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done           <= 1'b0;
      rx             <= '0;
      ry             <= '0;
      rz             <= '0;
      scalar_out     <= '0;
      saturated      <= 1'b0;
      divide_by_zero <= 1'b0;
    end else begin
      done <= ev[EL-1];
      if (ev[EL-1]) begin
        rx             <= fvec[0];
        ry             <= fvec[1];
        rz             <= fvec[2];
        scalar_out     <= fsc;
        saturated      <= fsat;
        divide_by_zero <= fdz;
      end else begin
        rx             <= '0;
        ry             <= '0;
        rz             <= '0;
        scalar_out     <= '0;
        saturated      <= 1'b0;
        divide_by_zero <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    divide_by_zero |-> (done && rx == 0 && ry == 0 && rz == 0 && scalar_out == 0))
    else $error("divide by zero result not cleared");
  a_dz_nosat: assert property (@(posedge clk) disable iff (rst)
    divide_by_zero |-> !saturated)
    else $error("divide by zero also flagged saturation");
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> (scalar_out == 0 || (rx == 0 && ry == 0 && rz == 0)))
    else $error("vector and scalar result both present");
  a_idle_flags: assert property (@(posedge clk) disable iff (rst)
    !done |-> (!saturated && !divide_by_zero))
    else $error("flags set without a result");
`endif
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the three-component fixed-point vector unit.
`timescale 1ns / 1ps
module testbench;
  import v3au_pkg::*;

  localparam int W = 32;
  localparam logic signed [W-1:0] VMAX = 32'sh7fffffff;
  localparam logic signed [W-1:0] VMIN = 32'sh80000000;
  localparam logic signed [W-1:0] ONE  = 32'sh00010000;
  localparam op_t OP_BAD_LO = 4'd12;
  localparam op_t OP_BAD_HI = 4'd15;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [W-1:0] x, y, z, s;
    logic sat, dz;
  } vec_result_t;

  typedef struct {
    op_t op;
    logic signed [W-1:0] ax, ay, az, bx, by, bz, sc;
    bit typed;
    vec_result_t res;
  } cmd_row_t;

  logic clk = 1'b0, rst = 1'b1, start = 1'b0;
  logic busy, done, saturated, divide_by_zero;
  op_t operation = OP_ADD;
  logic signed [W-1:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
  logic signed [W-1:0] scalar_in = '0;
  logic signed [W-1:0] rx, ry, rz, scalar_out;

  // Typed expectation that travels with the item on the bus
  bit typed_valid = 1'b0;
  vec_result_t typed_res;

  vec_result_t pending_results[$];
  int mismatches = 0, results_seen = 0, items_sent = 0, cycles = 0;
  int idle_pct = 0;
  cmd_row_t rows[$];

  vector3_arithmetic_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz), .scalar_in(scalar_in),
    .done(done), .rx(rx), .ry(ry), .rz(rz), .scalar_out(scalar_out),
    .saturated(saturated), .divide_by_zero(divide_by_zero)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Clamp a wide value to the component range, flag any clamp
  function automatic logic signed [W-1:0] clamp(input logic signed [127:0] v, inout logic f);
    if (v > 128'(VMAX)) begin
      f = 1'b1;
      return VMAX;
    end
    if (v < 128'(VMIN)) begin
      f = 1'b1;
      return VMIN;
    end
    return v[W-1:0];
  endfunction

  // Round a Q.32 product back to Q.16, halves up
  function automatic logic signed [127:0] rnd(input logic signed [127:0] p);
    return (p + 128'sd32768) >>> 16;
  endfunction

  function automatic logic signed [127:0] root_floor(input logic signed [127:0] n);
    logic [127:0] r, t;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic vec_result_t vector_math(input op_t op,
      input logic signed [W-1:0] ix, iy, iz, jx, jy, jz, isc);
    logic signed [127:0] a[3], b[3], s, acc, len;
    vec_result_t r;
    a[0] = ix; a[1] = iy; a[2] = iz;
    b[0] = jx; b[1] = jy; b[2] = jz;
    s = isc;
    r = '{x: '0, y: '0, z: '0, s: '0, sat: 1'b0, dz: 1'b0};
    case (op)
      OP_ADD: begin
        r.x = clamp(a[0] + b[0], r.sat);
        r.y = clamp(a[1] + b[1], r.sat);
        r.z = clamp(a[2] + b[2], r.sat);
      end
      OP_SUB: begin
        r.x = clamp(a[0] - b[0], r.sat);
        r.y = clamp(a[1] - b[1], r.sat);
        r.z = clamp(a[2] - b[2], r.sat);
      end
      OP_MUL: begin
        r.x = clamp(rnd(a[0] * b[0]), r.sat);
        r.y = clamp(rnd(a[1] * b[1]), r.sat);
        r.z = clamp(rnd(a[2] * b[2]), r.sat);
      end
      OP_SCALE: begin
        r.x = clamp(rnd(a[0] * s), r.sat);
        r.y = clamp(rnd(a[1] * s), r.sat);
        r.z = clamp(rnd(a[2] * s), r.sat);
      end
      OP_DIV: begin
        if (s == 0) r.dz = 1'b1;
        else begin
          r.x = clamp((a[0] <<< 16) / s, r.sat);
          r.y = clamp((a[1] <<< 16) / s, r.sat);
          r.z = clamp((a[2] <<< 16) / s, r.sat);
        end
      end
      OP_DOT: r.s = clamp(rnd(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), r.sat);
      OP_CROSS: begin
        r.x = clamp(rnd(a[1] * b[2] - a[2] * b[1]), r.sat);
        r.y = clamp(rnd(a[2] * b[0] - a[0] * b[2]), r.sat);
        r.z = clamp(rnd(a[0] * b[1] - a[1] * b[0]), r.sat);
      end
      OP_LEN, OP_LENSQ, OP_NORM, OP_LEN2D, OP_LENSQ2D: begin
        acc = a[0] * a[0] + a[1] * a[1];
        if (op <= OP_NORM) acc = acc + a[2] * a[2];
        if (op == OP_LEN || op == OP_LEN2D) r.s = clamp(root_floor(acc), r.sat);
        else if (op == OP_LENSQ || op == OP_LENSQ2D) r.s = clamp(rnd(acc), r.sat);
        else if (acc != 0) begin
          len = root_floor(acc);
          r.x = clamp((a[0] <<< 16) / len, r.sat);
          r.y = clamp((a[1] <<< 16) / len, r.sat);
          r.z = clamp((a[2] <<< 16) / len, r.sat);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Check finished items, then log newly taken ones
  always @(posedge clk) begin
    vec_result_t e;
    if (!rst) begin
      if (done) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: result with no item outstanding");
        end else begin
          e = pending_results.pop_front();
          if (rx !== e.x || ry !== e.y || rz !== e.z || scalar_out !== e.s ||
              saturated !== e.sat || divide_by_zero !== e.dz) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: exp %h %h %h %h sat %b dz %b, got %h %h %h %h sat %b dz %b",
                       e.x, e.y, e.z, e.s, e.sat, e.dz,
                       rx, ry, rz, scalar_out, saturated, divide_by_zero);
          end
        end
      end
      if (start && !busy) begin
        if (typed_valid) pending_results.push_back(typed_res);
        else pending_results.push_back(vector_math(operation, ax, ay, az, bx, by, bz,
                                                   scalar_in));
      end
    end
  end

  // Hard stop
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("vector3_arithmetic_unit test failed");
      $finish;
    end
  end

  // Present one item and hold it until taken
  task automatic issue_item(input cmd_row_t c);
    logic taken;
    operation <= c.op;
    ax <= c.ax; ay <= c.ay; az <= c.az;
    bx <= c.bx; by <= c.by; bz <= c.bz;
    scalar_in <= c.sc;
    typed_valid <= c.typed;
    typed_res <= c.res;
    start <= 1'b1;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    items_sent++;
    // Idle each following cycle with the given chance
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic signed [W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VMAX;
      1: return VMIN;
      2: return '0;
      3, 4, 5: return $urandom;
      default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  function automatic cmd_row_t random_item();
    cmd_row_t c;
    c.op = ($urandom_range(0, 19) == 0) ? op_t'($urandom_range(12, 15))
                                        : op_t'($urandom_range(0, 11));
    c.ax = pick_value(); c.ay = pick_value(); c.az = pick_value();
    c.bx = pick_value(); c.by = pick_value(); c.bz = pick_value();
    c.sc = pick_value();
    c.typed = 1'b0;
    c.res = '{x: '0, y: '0, z: '0, s: '0, sat: 1'b0, dz: 1'b0};
    return c;
  endfunction

  task automatic add_row(input op_t op, input logic signed [W-1:0] a0, a1, a2, b0, b1, b2, sc,
                         input bit typed, input vec_result_t res);
    rows.push_back('{op: op, ax: a0, ay: a1, az: a2, bx: b0, by: b1, bz: b2, sc: sc,
                     typed: typed, res: res});
  endtask

  initial begin
    vec_result_t zero, nores;
    zero = '{x: '0, y: '0, z: '0, s: '0, sat: 1'b0, dz: 1'b0};
    nores = zero;

    // Hand-checked rows first, then rows left to the predictor
    add_row(OP_ADD, VMAX, 0, 0, VMAX, 0, 0, 0, 1,
            '{x: VMAX, y: '0, z: '0, s: '0, sat: 1'b1, dz: 1'b0});
    add_row(OP_SUB, VMIN, 0, 0, ONE, 0, 0, 0, 1,
            '{x: VMIN, y: '0, z: '0, s: '0, sat: 1'b1, dz: 1'b0});
    add_row(OP_DIV, ONE, VMAX, VMIN, 0, 0, 0, 0, 1,
            '{x: '0, y: '0, z: '0, s: '0, sat: 1'b0, dz: 1'b1});
    add_row(OP_NORM, 0, 0, 0, ONE, ONE, ONE, ONE, 1, zero);
    add_row(OP_LEN, 0, 0, 0, VMAX, VMAX, VMAX, VMAX, 1, zero);
    add_row(OP_LENSQ, VMAX, VMAX, VMAX, 0, 0, 0, 0, 1,
            '{x: '0, y: '0, z: '0, s: VMAX, sat: 1'b1, dz: 1'b0});
    add_row(OP_BAD_LO, VMAX, VMIN, ONE, VMAX, VMIN, ONE, VMAX, 1, zero);
    add_row(OP_BAD_HI, VMIN, VMAX, -ONE, VMIN, VMAX, -ONE, VMIN, 1, zero);
    add_row(OP_ADD, 3 * ONE, -ONE, 7, ONE, ONE, -7, 0, 0, nores);
    add_row(OP_SUB, VMAX, VMIN, 5, VMIN, VMAX, 5, 0, 0, nores);
    add_row(OP_MUL, VMIN, 1, -ONE, VMIN, 32'sh8000, ONE / 2, 0, 0, nores);
    add_row(OP_SCALE, 1, -1, VMAX, 0, 0, 0, 32'sh8000, 0, nores);
    add_row(OP_SCALE, VMIN, VMAX, ONE, 0, 0, 0, VMIN, 0, nores);
    add_row(OP_DIV, VMIN, VMAX, 3 * ONE, 0, 0, 0, -ONE, 0, nores);
    add_row(OP_DIV, 7, -7, ONE, 0, 0, 0, 3 * ONE, 0, nores);
    add_row(OP_DOT, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, 0, 0, nores);
    add_row(OP_DOT, ONE, 2 * ONE, -ONE, 3 * ONE, -ONE, ONE, 0, 0, nores);
    add_row(OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0, 0, nores);
    add_row(OP_CROSS, VMAX, VMIN, VMAX, VMIN, VMAX, VMIN, 0, 0, nores);
    add_row(OP_LEN, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0, nores);
    add_row(OP_LEN, VMIN, VMIN, VMIN, 0, 0, 0, 0, 0, nores);
    add_row(OP_NORM, 3 * ONE, -4 * ONE, 12 * ONE, 0, 0, 0, 0, 0, nores);
    add_row(OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0, nores);
    add_row(OP_LEN2D, VMAX, VMIN, 99, 0, 0, 0, 0, 0, nores);
    add_row(OP_LENSQ2D, ONE, -ONE, VMAX, 0, 0, 0, 0, 0, nores);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    idle_pct = 24;
    foreach (rows[i]) issue_item(rows[i]);

    // Random items: sender idles sometimes, then often, then never
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 24 : (phase == 1) ? 67 : 0;
      repeat (310) issue_item(random_item());
      // Hold off until the pipe has drained
      start <= 1'b0;
      typed_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      @(posedge clk);
    end

    repeat (80) @(posedge clk);
    $display("Sent %0d items over all twelve operations plus unknown codes;", items_sent);
    $display("checked %0d results across sender idle rates 24, 67 and 0 percent.",
             results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("vector3_arithmetic_unit test passed");
    end else begin
      $display("vector3_arithmetic_unit test failed");
    end
    $finish;
  end
endmodule

// File: vector3_arithmetic_unit.f
sv/v3au_pkg.sv
sv/v3au_lane.sv
sv/v3au_sqrt.sv
sv/v3au_div.sv
sv/vector3_arithmetic_unit.sv
tb/testbench.sv
